### hdl/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside of reset
`define ASSERT_DIS(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

### hdl/lms_pkg.sv
package lms_pkg;

   localparam int unsigned VALUE_W = 9;
   localparam int unsigned LEN_W   = 16;
   localparam logic [LEN_W-1:0] LEN_MAX = 16'hFFFF;

   // direction register codes
   localparam logic DIR_NON_DECREASING = 1'b0;
   localparam logic DIR_NON_INCREASING = 1'b1;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CLEAR = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_WRITE = 5'b10000
   } state_type;

endpackage

### hdl/lms_req_if.sv
interface lms_req_if import lms_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;
   logic               restart;

   modport source (output valid, value, restart, input ready);
   modport sink   (input valid, value, restart, output ready);
endinterface

### hdl/lms_rsp_if.sv
interface lms_rsp_if import lms_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] ending_length;
   logic [LEN_W-1:0] best_length;

   modport source (output valid, ending_length, best_length, input ready);
   modport sink   (input valid, ending_length, best_length, output ready);
endinterface

### hdl/lms_ram.sv
module lms_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 512,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/longest_monotone_subsequence_dp.sv
// longest monotone subsequence over a stream of bounded values. a table in one
// synchronous ram, indexed by value, holds the longest run ending at each value.
// each item v scans the table over 0..v (direction 0, non-decreasing) or over
// v..VALUE_COUNT-1 (direction 1, non-increasing), one ram read per cycle, then
// writes the peak plus one back at v (saturating at 65535) and returns that
// ending length with the best length so far. values at or above VALUE_COUNT are
// clamped to the last entry. an item without restart runs a scan, a drain step
// and a write-back, which waits for a free output slot; the scan is bound by
// the single ram read port. an item with restart sweeps the whole table to
// zero, one entry a cycle, then writes back. after reset the same sweep runs
// with req_ch.ready low; csr writes are taken at any time but belong only in
// idle periods. the result sits in an output register, so the next item is
// taken while a result still waits for rsp_ch.ready.
`include "assert_macros.svh"

module longest_monotone_subsequence_dp import lms_pkg::*; #(
   parameter int unsigned VALUE_COUNT = 512
) (
   input  logic      clock,
   input  logic      reset,
   lms_req_if.sink   req_ch,
   lms_rsp_if.source rsp_ch,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data
);

   // table index width and clamp compare width (VALUE_COUNT up to 4096)
   localparam int unsigned IDX_W = (VALUE_COUNT > 1) ? $clog2(VALUE_COUNT) : 1;
   localparam int unsigned CMP_W = 13;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VALUE_COUNT - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] addr_ff, addr_in;       // sweep / scan address
   logic [IDX_W-1:0] hi_ff, hi_in;           // last scan address
   logic [IDX_W-1:0] v_ff, v_in;             // clamped value of the item
   logic [LEN_W-1:0] peak_ff, peak_in;
   logic             rd_pend_ff, rd_pend_in; // read data valid this cycle
   logic             clr_item_ff, clr_item_in;
   logic [LEN_W-1:0] best_ff, best_in;
   logic             dir_ff, dir_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0] rsp_end_ff, rsp_end_in;
   logic [LEN_W-1:0] rsp_best_ff, rsp_best_in;

   logic             ram_we;
   logic [IDX_W-1:0] ram_waddr;
   logic [LEN_W-1:0] ram_wdata;
   logic [LEN_W-1:0] ram_rdata;

   logic [CMP_W-1:0] value_ext;
   logic [IDX_W-1:0] req_idx;
   logic             req_accept;
   logic             out_free;
   logic [LEN_W-1:0] next_len;

   // clamp the incoming value into the table
   assign value_ext  = CMP_W'(req_ch.value);
   assign req_idx    = (value_ext >= CMP_W'(VALUE_COUNT)) ? LAST_IDX
                                                          : value_ext[IDX_W-1:0];
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_accept = req_ch.valid && req_ch.ready;

   // output slot is free when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // saturating peak plus one
   assign next_len = (peak_ff == LEN_MAX) ? LEN_MAX : peak_ff + LEN_W'(1);

   assign dir_in = csr_wr_en ? csr_wr_data : dir_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      hi_in        = hi_ff;
      v_in         = v_ff;
      peak_in      = peak_ff;
      rd_pend_in   = 1'b0;
      clr_item_in  = clr_item_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_end_in   = rsp_end_ff;
      rsp_best_in  = rsp_best_ff;
      ram_we       = 1'b0;
      ram_waddr    = addr_ff;
      ram_wdata    = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               v_in    = req_idx;
               peak_in = '0;
               if (req_ch.restart) begin
                  // sweep the table to zero, then record a run of one
                  state_in    = ST_CLEAR;
                  addr_in     = '0;
                  clr_item_in = 1'b1;
                  best_in     = '0;
               end else begin
                  state_in = ST_SCAN;
                  if (dir_ff == DIR_NON_INCREASING) begin
                     addr_in = req_idx;
                     hi_in   = LAST_IDX;
                  end else begin
                     addr_in = '0;
                     hi_in   = req_idx;
                  end
               end
            end
         end
         ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = addr_ff;
            ram_wdata = '0;
            if (addr_ff == LAST_IDX) begin
               state_in = clr_item_ff ? ST_WRITE : ST_IDLE;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_SCAN: begin
            // ram reads addr_ff now, data lands next cycle
            rd_pend_in = 1'b1;
            if (rd_pend_ff && (ram_rdata > peak_ff)) begin
               peak_in = ram_rdata;
            end
            if (addr_ff == hi_ff) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            // data of the last scan read
            if (ram_rdata > peak_ff) begin
               peak_in = ram_rdata;
            end
            state_in = ST_WRITE;
         end
         ST_WRITE: begin
            // the peak covers entry v itself, so next_len never lowers it
            if (out_free) begin
               ram_we       = 1'b1;
               ram_waddr    = v_ff;
               ram_wdata    = next_len;
               best_in      = (next_len > best_ff) ? next_len : best_ff;
               rsp_valid_in = 1'b1;
               rsp_end_in   = next_len;
               rsp_best_in  = (next_len > best_ff) ? next_len : best_ff;
               clr_item_in  = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // power-up clearing pass over the whole table
         state_ff     <= ST_CLEAR;
         addr_ff      <= '0;
         clr_item_ff  <= 1'b0;
         rd_pend_ff   <= 1'b0;
         best_ff      <= '0;
         dir_ff       <= DIR_NON_DECREASING;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         clr_item_ff  <= clr_item_in;
         rd_pend_ff   <= rd_pend_in;
         best_ff      <= best_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      hi_ff       <= hi_in;
      v_ff        <= v_in;
      peak_ff     <= peak_in;
      rsp_end_ff  <= rsp_end_in;
      rsp_best_ff <= rsp_best_in;
   end

   lms_ram #(
      .WIDTH (LEN_W),
      .DEPTH (VALUE_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (addr_ff),
      .rd_data (ram_rdata)
   );

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.ending_length = rsp_end_ff;
   assign rsp_ch.best_length   = rsp_best_ff;

   // table is written only by the sweep or the final write-back
   `ASSERT_ALWAYS(a_we_state, clock, !ram_we || (state_ff == ST_CLEAR) || (state_ff == ST_WRITE), "table write outside clear or write-back")
   // a result never reports a best below its own ending length
   `ASSERT_DIS(a_best_ge_end, clock, reset, rsp_ch.valid |-> (rsp_ch.best_length >= rsp_ch.ending_length), "best length below ending length")
   // every result records at least a run of one
   `ASSERT_DIS(a_end_nonzero, clock, reset, rsp_ch.valid |-> (rsp_ch.ending_length != '0), "zero ending length")
   // an accepted item starts a scan or a clearing sweep
   `ASSERT_DIS(a_accept_next, clock, reset, req_accept |=> ((state_ff == ST_SCAN) || (state_ff == ST_CLEAR)), "accepted item did not start")
   // scan addresses stay inside the table
   `ASSERT_DIS(a_scan_range, clock, reset, (state_ff == ST_SCAN) |-> ((addr_ff <= hi_ff) && (hi_ff <= LAST_IDX)), "scan address out of range")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import lms_pkg::*;

   localparam int unsigned TABLE_DEPTH = 512;

   typedef struct packed {
      logic [LEN_W-1:0] ending_length;
      logic [LEN_W-1:0] best_length;
   } lengths_type;

   logic clock       = 1'b0;
   logic reset       = 1'b1;
   logic csr_wr_en   = 1'b0;
   logic csr_wr_data = 1'b0;

   lms_req_if req_ch ();
   lms_rsp_if rsp_ch ();

   // shadow copy of the block state, updated when an item is accepted
   logic [LEN_W-1:0] length_table [TABLE_DEPTH];
   logic [LEN_W-1:0] best_shadow;
   logic             direction_shadow;

   // lengths still owed by the block, oldest first
   lengths_type pending_lengths [$];

   int unsigned        sender_idle_pct   = 0;
   int unsigned        receiver_idle_pct = 0;
   int unsigned        hold_cycles_left  = 0;
   int unsigned        error_count       = 0;
   logic [VALUE_W-1:0] walk_value        = '0;

   longest_monotone_subsequence_dp i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // ending length and best length for one value, updates the shadow state
   function automatic lengths_type predict_lengths(input logic [VALUE_W-1:0] value,
                                                   input logic restart);
      int unsigned idx;
      int unsigned lo;
      int unsigned hi;
      int unsigned peak;
      int unsigned next_len;
      lengths_type result;
      if (restart) begin
         foreach (length_table[i]) length_table[i] = '0;
         best_shadow = '0;
      end
      // values beyond the table land on the last entry
      idx = 32'(value);
      if (idx >= TABLE_DEPTH) idx = TABLE_DEPTH - 1;
      // non-increasing looks at entries from v up, non-decreasing from 0 to v
      lo = (direction_shadow == DIR_NON_INCREASING) ? idx : 0;
      hi = (direction_shadow == DIR_NON_INCREASING) ? TABLE_DEPTH - 1 : idx;
      peak = 0;
      for (int unsigned i = lo; i <= hi; i++) begin
         if (length_table[i] > peak) peak = 32'(length_table[i]);
      end
      // saturate, a full-length entry stays full
      next_len = peak + 1;
      if (next_len > LEN_MAX) next_len = LEN_MAX;
      if (next_len > length_table[idx]) length_table[idx] = LEN_W'(next_len);
      else next_len = 32'(length_table[idx]);
      if (next_len > best_shadow) best_shadow = LEN_W'(next_len);
      result.ending_length = LEN_W'(next_len);
      result.best_length   = best_shadow;
      return result;
   endfunction

   // next random item: mostly a walk along the current direction with small
   // steps, so long runs build up; the rest is uniform noise and the extremes
   function automatic void next_random_item(output logic [VALUE_W-1:0] value,
                                            output logic restart);
      int unsigned roll;
      int unsigned step;
      roll    = $urandom_range(99);
      step    = $urandom_range(6);
      restart = ($urandom_range(49) == 0);
      if (roll < 55) begin
         if (direction_shadow == DIR_NON_DECREASING) begin
            if (walk_value + step > TABLE_DEPTH - 1) walk_value = VALUE_W'($urandom_range(63));
            else walk_value = VALUE_W'(walk_value + step);
         end else begin
            if (walk_value < step)
               walk_value = VALUE_W'($urandom_range(TABLE_DEPTH - 1, 448));
            else walk_value = VALUE_W'(walk_value - step);
         end
         value = walk_value;
      end else if (roll < 85) begin
         value = VALUE_W'($urandom_range(TABLE_DEPTH - 1));
      end else begin
         value = $urandom_range(1) ? VALUE_W'(TABLE_DEPTH - 1) : '0;
      end
   endfunction

   // offer one item, with random idle cycles ahead of it; valid stays high
   // after acceptance so back-to-back items need no second assignment
   task automatic send_item(input logic [VALUE_W-1:0] value, input logic restart);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.value   <= value;
      req_ch.restart <= restart;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_lengths.push_back(predict_lengths(value, restart));
   endtask

   // direction register write, one cycle of write enable
   task automatic write_direction(input logic dir);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= dir;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      direction_shadow = dir;
   endtask

   // stop offering, let every owed item come back, then let the table
   // write-back finish before anything else changes
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (pending_lengths.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
   endtask

   // non-decreasing: repeats, both ends, the value 300, a drop, a restart
   task automatic test_directed_non_decreasing();
      sender_idle_pct   = 0;
      receiver_idle_pct = 0;
      write_direction(DIR_NON_DECREASING);
      send_item(9'd0, 1'b0);
      send_item(9'd0, 1'b0);
      send_item(9'd511, 1'b0);
      send_item(9'd5, 1'b0);
      send_item(9'd5, 1'b0);
      send_item(9'd300, 1'b0);
      send_item(9'd4, 1'b0);
      send_item(9'd511, 1'b0);
      send_item(9'h155, 1'b0);
      send_item(9'd100, 1'b1);
      send_item(9'd511, 1'b0);
      send_item(9'h0aa, 1'b0);
      wait_drained();
   endtask

   // non-increasing: restart on the top value, full-length scans from 0
   task automatic test_directed_non_increasing();
      write_direction(DIR_NON_INCREASING);
      send_item(9'd511, 1'b1);
      send_item(9'd511, 1'b0);
      send_item(9'd300, 1'b0);
      send_item(9'd300, 1'b0);
      send_item(9'd0, 1'b0);
      send_item(9'd256, 1'b0);
      send_item(9'd0, 1'b0);
      send_item(9'd1, 1'b1);
      send_item(9'd0, 1'b0);
      send_item(9'd511, 1'b0);
      send_item(9'h1ff, 1'b0);
      wait_drained();
   endtask

   // receiver holds off for a long stretch while cheap items keep coming,
   // so the output register fills and the block stalls its input
   task automatic test_output_backpressure();
      write_direction(DIR_NON_DECREASING);
      hold_cycles_left = 1500;
      send_item(9'd0, 1'b1);
      for (int i = 1; i < 12; i++) send_item(VALUE_W'(i), 1'b0);
      wait_drained();
   endtask

   // random items, half in each direction, with the given idle rates
   task automatic test_random_traffic(input int unsigned count,
                                      input int unsigned s_pct,
                                      input int unsigned r_pct);
      logic [VALUE_W-1:0] value;
      logic               restart;
      sender_idle_pct   = s_pct;
      receiver_idle_pct = r_pct;
      for (int half = 0; half < 2; half++) begin
         write_direction(half == 0 ? DIR_NON_DECREASING : DIR_NON_INCREASING);
         walk_value = (half == 0) ? VALUE_W'(0) : VALUE_W'(TABLE_DEPTH - 1);
         for (int unsigned n = 0; n < count / 2; n++) begin
            next_random_item(value, restart);
            send_item(value, restart);
         end
         wait_drained();
      end
   endtask

   // receiver: random ready, or held low while a hold-off is counting down
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_cycles_left != 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles_left = hold_cycles_left - 1;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // every accepted result against the oldest owed lengths
   always @(posedge clock) begin : check_lengths
      lengths_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_lengths.size() == 0) begin
            error_count++;
            $display("%0t: unexpected item, expected none, actual %0d / %0d", $time,
                     rsp_ch.ending_length, rsp_ch.best_length);
         end else begin
            want = pending_lengths.pop_front();
            if (rsp_ch.ending_length !== want.ending_length)
               report_mismatch("ending_length", 32'(want.ending_length),
                               32'(rsp_ch.ending_length));
            if (rsp_ch.best_length !== want.best_length)
               report_mismatch("best_length", 32'(want.best_length),
                               32'(rsp_ch.best_length));
         end
      end
   end

   initial begin
      req_ch.valid   = 1'b0;
      req_ch.value   = '0;
      req_ch.restart = 1'b0;
      rsp_ch.ready   = 1'b0;
      foreach (length_table[i]) length_table[i] = '0;
      best_shadow      = '0;
      direction_shadow = DIR_NON_DECREASING;

      // the block clears its table after reset with input ready low, the
      // first item simply waits for it
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_directed_non_decreasing();
      test_directed_non_increasing();
      test_output_backpressure();
      test_random_traffic(380, 21, 80);
      test_random_traffic(380, 80, 21);
      test_random_traffic(380, 0, 0);

      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_lengths.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // hang guard, several times the slowest correct run
   initial begin
      #50_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

### longest_monotone_subsequence_dp.f
+incdir+hdl
hdl/lms_pkg.sv
hdl/lms_req_if.sv
hdl/lms_rsp_if.sv
hdl/lms_ram.sv
hdl/longest_monotone_subsequence_dp.sv
tb/testbench.sv
